>>> rtl/twss_pkg.sv
// Shared constants, types and controller state codes for the segment sorter.
`timescale 1ns / 1ps

package twss_pkg;

    // Segment buffer geometry
    localparam int SEG_DEPTH = 32;
    localparam int IDX_W     = $clog2(SEG_DEPTH);
    localparam int FILL_W    = $clog2(SEG_DEPTH + 1);

    // Field widths
    localparam int TIME_W = 32;
    localparam int NS_W   = 40;
    localparam int TICK_W = 8;

    // Wrap detection
    localparam logic [NS_W-1:0]   WRAP_GAP_NS     = 40'd43_000_000;
    localparam logic [NS_W-1:0]   PREV_TIME_RESET = 40'hff_ffff_ffff;
    localparam logic [TICK_W-1:0] TICK_RESET      = 8'd16;

    // Pass-through part of a stored readout
    typedef struct packed {
        logic [15:0] digitizer;
        logic [15:0] adc;
        logic [7:0]  channel;
    } t_payload;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_TEST,
        S_DRAIN_PRE,
        S_INSERT,
        S_DRAIN_EOP
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic capture;   // take the input beat and its scaled time
        logic test;      // wrap test and wrap count update
        logic insert;    // sorted insert of the held readout
        logic emit;      // move the next buffered readout to the output register
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic wrap;       // held readout marks a timer wrap
        logic full;       // buffer holds SEG_DEPTH readouts
        logic fill_zero;  // buffer is empty
        logic eop;        // held readout closes its packet
        logic out_free;   // output register can take a beat this cycle
        logic last;       // read pointer sits on the final buffered readout
    } t_status;

endpackage

>>> rtl/twss_ctrl.sv
// Controller state machine: sequences wrap test, drains and sorted inserts.
`timescale 1ns / 1ps

module twss_ctrl
    import twss_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = (r_state != S_IDLE);
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_TEST;
                end
            end
            S_TEST: begin
                o_cmd.test = 1'b1;
                if ((i_status.wrap && !i_status.fill_zero) ||
                    (!i_status.wrap && i_status.full)) begin
                    n_state = S_DRAIN_PRE;
                end else begin
                    o_cmd.insert = 1'b1;
                    n_state      = i_status.eop ? S_DRAIN_EOP : S_IDLE;
                end
            end
            S_DRAIN_PRE: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_status.last) begin
                        n_state = S_INSERT;
                    end
                end
            end
            S_INSERT: begin
                o_cmd.insert = 1'b1;
                n_state      = i_status.eop ? S_DRAIN_EOP : S_IDLE;
            end
            S_DRAIN_EOP: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_status.last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // An accepted beat always goes straight to the wrap test
    a_accept_to_test: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state == S_TEST))
        else $error("accepted beat did not enter the wrap test");

    // The last drained readout of a packet returns the controller to idle
    a_eop_drain_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRAIN_EOP && o_cmd.emit && i_status.last) |=> (r_state == S_IDLE))
        else $error("end-of-packet drain did not finish in idle");

endmodule

>>> rtl/twss_dpath.sv
// Datapath: tick scaling, wrap test, sorted segment row and output register.
`timescale 1ns / 1ps

module twss_dpath
    import twss_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [TICK_W-1:0] i_cfg_data,
    input  logic [TIME_W-1:0] i_readout_time,
    input  logic [7:0]        i_readout_channel,
    input  logic [15:0]       i_readout_adc,
    input  logic [15:0]       i_readout_digitizer,
    input  logic [7:0]        i_cassette_index,
    input  logic              i_end_of_packet,
    input  t_cmd              i_cmd,
    output t_status           o_status,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [TIME_W-1:0] o_sorted_time,
    output logic [7:0]        o_sorted_channel,
    output logic [15:0]       o_sorted_adc,
    output logic [15:0]       o_sorted_digitizer,
    output logic [7:0]        o_out_cassette,
    output logic              o_segment_last,
    output logic              o_early_flush,
    output logic [31:0]       o_wraps_seen
);

    // Configuration and running state
    logic [TICK_W-1:0] r_tick_len;
    logic [NS_W-1:0]   r_prev_ns;
    logic [31:0]       r_wrap_cnt;
    logic [FILL_W-1:0] r_fill;
    logic [IDX_W-1:0]  r_rd_idx;
    logic              r_early;

    // Held input beat
    logic [TIME_W-1:0] r_cur_time;
    t_payload          r_cur_pay;
    logic [7:0]        r_cur_cas;
    logic              r_cur_eop;
    logic [NS_W-1:0]   r_cur_ns;

    // Sorted segment row
    logic [TIME_W-1:0] r_seg_time [SEG_DEPTH];
    t_payload          r_seg_pay  [SEG_DEPTH];
    logic [TIME_W-1:0] n_seg_time [SEG_DEPTH];
    t_payload          n_seg_pay  [SEG_DEPTH];
    logic [SEG_DEPTH-1:0] w_le;

    // Output register
    logic              r_out_valid;
    logic [TIME_W-1:0] r_out_time;
    t_payload          r_out_pay;
    logic [7:0]        r_out_cas;
    logic              r_out_last;
    logic              r_out_early;
    logic [31:0]       r_out_wraps;

    logic [NS_W-1:0] w_time_ns;
    logic [NS_W-1:0] w_back;
    logic            w_wrap;
    logic            w_last;
    logic            w_out_free;

    // Tick scaling, 32 x 8 into 40 bits
    assign w_time_ns = NS_W'(i_readout_time) * NS_W'(r_tick_len);

    // Wrap test: scaled time fell back by at least the gap
    assign w_back = r_prev_ns - r_cur_ns;
    assign w_wrap = (r_prev_ns >= r_cur_ns) && (w_back >= WRAP_GAP_NS);

    assign w_last     = (FILL_W'(r_rd_idx) == (r_fill - FILL_W'(1)));
    assign w_out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        o_status.wrap      = w_wrap;
        o_status.full      = (r_fill == FILL_W'(SEG_DEPTH));
        o_status.fill_zero = (r_fill == '0);
        o_status.eop       = r_cur_eop;
        o_status.out_free  = w_out_free;
        o_status.last      = w_last;
    end

    // Parallel compare: entries at or below the new time form a prefix and stay;
    // the first entry past it takes the new readout, the rest shift up by one
    always_comb begin
        for (int i = 0; i < SEG_DEPTH; i++) begin
            w_le[i] = (FILL_W'(i) < r_fill) && (r_seg_time[i] <= r_cur_time);
        end
        // bottom slot keeps its entry or takes the new readout
        n_seg_time[0] = w_le[0] ? r_seg_time[0] : r_cur_time;
        n_seg_pay[0]  = w_le[0] ? r_seg_pay[0]  : r_cur_pay;
        for (int i = 1; i < SEG_DEPTH; i++) begin
            if (w_le[i]) begin
                n_seg_time[i] = r_seg_time[i];
                n_seg_pay[i]  = r_seg_pay[i];
            end else if (w_le[i-1]) begin
                n_seg_time[i] = r_cur_time;
                n_seg_pay[i]  = r_cur_pay;
            end else begin
                n_seg_time[i] = r_seg_time[i-1];
                n_seg_pay[i]  = r_seg_pay[i-1];
            end
        end
    end

    // Segment row
    always_ff @(posedge i_clk) begin
        if (i_cmd.insert) begin
            for (int i = 0; i < SEG_DEPTH; i++) begin
                r_seg_time[i] <= n_seg_time[i];
                r_seg_pay[i]  <= n_seg_pay[i];
            end
        end
    end

    // Held beat and its scaled time
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_cur_time          <= i_readout_time;
            r_cur_pay.channel   <= i_readout_channel;
            r_cur_pay.adc       <= i_readout_adc;
            r_cur_pay.digitizer <= i_readout_digitizer;
            r_cur_cas           <= i_cassette_index;
            r_cur_eop           <= i_end_of_packet;
            r_cur_ns            <= w_time_ns;
        end
    end

    // Control state of the datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_len <= TICK_RESET;
            r_prev_ns  <= PREV_TIME_RESET;
            r_wrap_cnt <= '0;
            r_fill     <= '0;
            r_rd_idx   <= '0;
            r_early    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_tick_len <= i_cfg_data;
            end
            if (i_cmd.test && w_wrap) begin
                r_wrap_cnt <= r_wrap_cnt + 32'd1;
            end
            if (i_cmd.insert) begin
                r_early   <= 1'b0;
                r_fill    <= r_fill + FILL_W'(1);
                r_prev_ns <= r_cur_eop ? PREV_TIME_RESET : r_cur_ns;
            end else if (i_cmd.test) begin
                r_early <= !w_wrap;
            end
            if (i_cmd.emit) begin
                if (w_last) begin
                    r_rd_idx <= '0;
                    r_fill   <= '0;
                end else begin
                    r_rd_idx <= r_rd_idx + IDX_W'(1);
                end
            end
        end
    end

    // Output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register payload; the wrap count travels with the beat
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_time  <= r_seg_time[r_rd_idx];
            r_out_pay   <= r_seg_pay[r_rd_idx];
            r_out_cas   <= r_cur_cas;
            r_out_last  <= w_last;
            r_out_early <= r_early;
            r_out_wraps <= r_wrap_cnt;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_sorted_time      = r_out_time;
    assign o_sorted_channel   = r_out_pay.channel;
    assign o_sorted_adc       = r_out_pay.adc;
    assign o_sorted_digitizer = r_out_pay.digitizer;
    assign o_out_cassette     = r_out_cas;
    assign o_segment_last     = r_out_last;
    assign o_early_flush      = r_out_early;
    assign o_wraps_seen       = r_out_wraps;

    // Fill count never passes the buffer depth
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_W'(SEG_DEPTH))
        else $error("segment fill beyond depth");

    // A sorted insert never lands in a full buffer
    a_insert_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.insert |-> (r_fill < FILL_W'(SEG_DEPTH)))
        else $error("insert into full segment");

    // A beat is drained only from a non-empty buffer into a free output register
    a_emit_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> ((r_fill != '0) && w_out_free))
        else $error("emit from empty buffer or into busy output register");

endmodule

>>> rtl/time_wrap_segment_sorter_top.sv
// Top level of the time wrap segment sorter: controller plus datapath.
`timescale 1ns / 1ps

// Readouts enter one at a time and are kept in a 32-entry row sorted by tick
// timestamp (equal times keep arrival order) using a parallel compare insert.
// A readout that causes no output is accepted and has its time scaled (32 x 8
// multiply), then gets the wrap test and the insert. When a segment drains, the
// buffered readouts pass one at a time into the output register, while it is
// free, through the row's single read port; a drain ahead of the insert (timer
// wrap or full buffer) is followed by an insert state. o_in_stall is high
// whenever an item is in work; the output register lets a finished beat wait
// on i_out_stall while the next readout is accepted. The user writes tick
// length via i_cfg_we / i_cfg_data while the block is idle; it is not enforced.
module time_wrap_segment_sorter_top
    import twss_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [TICK_W-1:0] i_cfg_data,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [TIME_W-1:0] i_readout_time,
    input  logic [7:0]        i_readout_channel,
    input  logic [15:0]       i_readout_adc,
    input  logic [15:0]       i_readout_digitizer,
    input  logic [7:0]        i_cassette_index,
    input  logic              i_end_of_packet,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [TIME_W-1:0] o_sorted_time,
    output logic [7:0]        o_sorted_channel,
    output logic [15:0]       o_sorted_adc,
    output logic [15:0]       o_sorted_digitizer,
    output logic [7:0]        o_out_cassette,
    output logic              o_segment_last,
    output logic              o_early_flush,
    output logic [31:0]       o_wraps_seen
);

    t_cmd    w_cmd;
    t_status w_status;

    // Sequencer
    twss_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // Storage, arithmetic and output register
    twss_dpath u_dpath (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_data          (i_cfg_data),
        .i_readout_time      (i_readout_time),
        .i_readout_channel   (i_readout_channel),
        .i_readout_adc       (i_readout_adc),
        .i_readout_digitizer (i_readout_digitizer),
        .i_cassette_index    (i_cassette_index),
        .i_end_of_packet     (i_end_of_packet),
        .i_cmd               (w_cmd),
        .o_status            (w_status),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_sorted_time       (o_sorted_time),
        .o_sorted_channel    (o_sorted_channel),
        .o_sorted_adc        (o_sorted_adc),
        .o_sorted_digitizer  (o_sorted_digitizer),
        .o_out_cassette      (o_out_cassette),
        .o_segment_last      (o_segment_last),
        .o_early_flush       (o_early_flush),
        .o_wraps_seen        (o_wraps_seen)
    );

endmodule
